@@ rtl/core/tsac_pkg.sv @@
// Shared types and constants of the tiled scanout address converter.
package tsac_pkg;

  localparam int unsigned XW = 11;
  localparam int unsigned YW = 11;
  localparam int unsigned WORDW = 32;
  localparam int unsigned PITCHW = 13;
  localparam int unsigned TWW = 14;
  localparam int unsigned THW = 12;
  localparam int unsigned AREAW = TWW + THW;
  localparam int unsigned IDXW = 26;
  localparam int unsigned ADDRW = 31;
  localparam int unsigned PIXW = 24;
  localparam int unsigned BASEW = 30;
  localparam int unsigned PADDRW = 5;

  // 32 MiB of 4-byte pixels
  localparam logic [AREAW-1:0] SURF_LIMIT_PIX = AREAW'(32'h0080_0000);

  typedef enum logic [2:0] {
    REG_ENABLE = 3'd0,
    REG_TILED  = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_PITCH  = 3'd4,
    REG_BASE   = 3'd5,
    REG_FORMAT = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    FMT_XRGB   = 2'd0,
    FMT_RGB565 = 2'd1,
    FMT_RGB332 = 2'd2
  } fmt_t;

  typedef struct packed {
    logic              ok;
    logic [PITCHW-1:0] pitch;
    logic [TWW-1:0]    tw;
  } geom_t;

endpackage

@@ rtl/core/tiled_scanout_address_convert_core.sv @@
// Top level: tiled/linear scanout address generation and pixel format conversion.
//
// Input stream s_*: one beat per pixel, tdata = {guest_word, y_pos, x_pos}.
// Output stream m_*: one beat per input beat, in order.
//   m_tdata = {display_pixel, byte_address}, m_tuser = {in_frame, geometry_ok}.
// Configuration goes through the APB port; registers sit at 4*index. Write
// only while no beats are in flight; the geometry check is registered and is
// ready for a beat accepted in the cycle right after the last write.
// The path from input beat to output beat runs through an input register,
// one shared multiplier (row times pitch, or tile row times tiled pitch) with
// the address adder, then the output register. Throughput is one beat per
// cycle. The input side keeps accepting while a result waits at the output,
// as long as the internal stage is free; when the receiver stalls with both
// stages full, s_tready drops and all data holds.
// Synchronous reset clears all configuration registers (geometry invalid)
// and empties both stages.
module tiled_scanout_address_convert_core
  import tsac_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1920,
  parameter int unsigned MAX_HEIGHT = 1200
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PADDRW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              s_tvalid,
  output logic              s_tready,
  // [10:0] x_pos, [21:11] y_pos, [53:22] guest_word, [55:54] zero
  input  logic [55:0]       s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // [30:0] byte_address, [54:31] display_pixel, [55] zero
  output logic [55:0]       m_tdata,
  // [0] geometry_ok, [1] in_frame
  output logic [1:0]        m_tuser
);

  logic              scanout_enable;
  logic              tiled_layout;
  logic [XW-1:0]     frame_width;
  logic [YW-1:0]     frame_height;
  logic [PITCHW-1:0] line_pitch;
  logic [31:0]       surface_base;
  logic [1:0]        display_format;

  logic      cfg_wr;
  reg_idx_t  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      scanout_enable <= 1'b0;
      tiled_layout   <= 1'b0;
      frame_width    <= '0;
      frame_height   <= '0;
      line_pitch     <= '0;
      surface_base   <= '0;
      display_format <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLE: scanout_enable <= pwdata[0];
        REG_TILED:  tiled_layout   <= pwdata[0];
        REG_WIDTH:  frame_width    <= pwdata[XW-1:0];
        REG_HEIGHT: frame_height   <= pwdata[YW-1:0];
        REG_PITCH:  line_pitch     <= pwdata[PITCHW-1:0];
        REG_BASE:   surface_base   <= pwdata;
        REG_FORMAT: display_format <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_ENABLE: prdata = {31'd0, scanout_enable};
      REG_TILED:  prdata = {31'd0, tiled_layout};
      REG_WIDTH:  prdata = {21'd0, frame_width};
      REG_HEIGHT: prdata = {21'd0, frame_height};
      REG_PITCH:  prdata = {19'd0, line_pitch};
      REG_BASE:   prdata = surface_base;
      REG_FORMAT: prdata = {30'd0, display_format};
      default:    prdata = '0;
    endcase
  end

  // geometry, registered from configuration
  logic [PITCHW-1:0] pitch_c;
  logic [TWW-1:0]    tw_c;
  logic [THW-1:0]    th_c;
  logic [AREAW-1:0]  area_c;
  geom_t             geom_next;
  geom_t             geom;

  always_comb begin
    pitch_c = (line_pitch < PITCHW'(frame_width)) ? PITCHW'(frame_width) : line_pitch;
    if (tiled_layout) begin
      tw_c = (TWW'(pitch_c) + TWW'(31)) & ~TWW'(31);
      th_c = (THW'(frame_height) + THW'(31)) & ~THW'(31);
    end else begin
      tw_c = TWW'(pitch_c);
      th_c = THW'(frame_height);
    end
    area_c = AREAW'(tw_c) * AREAW'(th_c);
    geom_next.ok = scanout_enable
                 && (frame_width != '0) && (frame_height != '0)
                 && (frame_width <= XW'(MAX_WIDTH))
                 && (frame_height <= YW'(MAX_HEIGHT))
                 && (tw_c != '0) && (th_c != '0)
                 && (area_c <= SURF_LIMIT_PIX);
    geom_next.pitch = pitch_c;
    geom_next.tw    = tw_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geom.ok <= 1'b0;
    end else begin
      geom.ok <= geom_next.ok;
    end
    geom.pitch <= geom_next.pitch;
    geom.tw    <= geom_next.tw;
  end

  // input stage
  logic             v1;
  logic [XW-1:0]    x1;
  logic [YW-1:0]    y1;
  logic [WORDW-1:0] word1;
  logic             en_out;

  assign en_out   = !m_tvalid || m_tready;
  assign s_tready = !v1 || en_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
    if (s_tready) begin
      x1    <= s_tdata[10:0];
      y1    <= s_tdata[21:11];
      word1 <= s_tdata[53:22];
    end
  end

  // address and pixel
  logic [YW-1:0]    mul_a;
  logic [TWW-1:0]   mul_b;
  logic [IDXW-1:0]  prod;
  logic [IDXW-1:0]  idx;
  logic [ADDRW-1:0] addr_c;
  logic [7:0]       r_c;
  logic [7:0]       g_c;
  logic [7:0]       b_c;
  logic [PIXW-1:0]  pix_c;
  logic             in_frame_c;

  always_comb begin
    mul_a = tiled_layout ? YW'(y1[YW-1:5]) : y1;
    mul_b = tiled_layout ? geom.tw : TWW'(geom.pitch);
    prod  = IDXW'(mul_a) * IDXW'(mul_b);
    if (tiled_layout) begin
      idx = (prod << 5)
          + IDXW'({x1[10:5], y1[4:1], x1[4:2], y1[0], x1[1:0]});
      idx[5] = idx[5] ^ y1[3];
    end else begin
      idx = prod + IDXW'(x1);
    end
    addr_c = ADDRW'(surface_base[BASEW-1:0]) + ADDRW'({idx, 2'b00});

    b_c = word1[31:24];
    g_c = word1[23:16];
    r_c = word1[15:8];
    case (display_format)
      FMT_XRGB:   pix_c = {r_c, g_c, b_c};
      FMT_RGB565: pix_c = {8'd0, r_c[7:3], g_c[7:2], b_c[7:3]};
      FMT_RGB332: pix_c = {16'd0, r_c[7:5], g_c[7:5], b_c[7:6]};
      default:    pix_c = '0;
    endcase
    in_frame_c = (x1 < frame_width) && (y1 < frame_height);
  end

  // output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en_out) begin
      m_tvalid <= v1;
    end
    if (en_out) begin
      m_tuser <= {in_frame_c, geom.ok};
      m_tdata <= geom.ok ? {1'b0, pix_c, addr_c} : '0;
    end
  end

endmodule

@@ rtl/core/tsac_checker.sv @@
// Port-level assertions for the scanout address converter, bound to the top level.
module tsac_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata,
  input logic [1:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_black_when_invalid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("nonzero data with invalid geometry");

endmodule

bind tiled_scanout_address_convert_core tsac_checker u_tsac_checker (.*);
